### src/anc_pkg.sv
`timescale 1ns / 1ps

package anc_pkg;

  // Input width and the number of low bits of it that are classified
  localparam int NUM_W       = 32;
  localparam int NUMBER_BITS = 32;
  localparam logic [NUM_W-1:0] NUMBER_MASK =
    NUM_W'((64'(1) << NUMBER_BITS) - 64'(1));

  // Result widths
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 35;

  // Trial divisor: odd, square never above 2^NUMBER_BITS - 1, plus one overshoot
  localparam int TRIAL_W = NUMBER_BITS / 2 + 1;
  localparam int PSQ_W   = 2 * TRIAL_W;

  // Exponent counter for one prime factor (lc), up to NUMBER_BITS + 1
  localparam int FACT_W = $clog2(NUMBER_BITS + 2);

  // Shared divider: dividend is SUM_W bits wide, one quotient bit a cycle
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // First odd trial divisor and its square
  localparam logic [TRIAL_W-1:0] TRIAL_FIRST    = TRIAL_W'(3);
  localparam logic [PSQ_W-1:0]   TRIAL_SQ_FIRST = PSQ_W'(9);
  localparam logic [TRIAL_W-1:0] TRIAL_STEP     = TRIAL_W'(2);

endpackage

### src/arithmetic_number_classifier.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_ready  | number
// output   | out_valid / out_ready| num_divisors, sigma, is_arith,
//          |                      | is_composite_arithmetic
//
// One item at a time; a shared restoring divider does every division. Each odd trial
// divisor costs a division. A factor found adds a shift-add multiply and a division;
// each prime found adds one more multiply. Zero goes straight to the result; every
// other item ends with a division of the sum by the count.
// Synchronous active-high reset returns to idle with no result pending.
// A waiting result holds only the final hand-off; the next item is taken meanwhile.

module arithmetic_number_classifier
  import anc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NUM_W-1:0]   number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] num_divisors,
  output logic [SUM_W-1:0]   sigma,
  output logic               is_arith,
  output logic               is_composite_arithmetic
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP,
    S_TEST,
    S_DIV,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state;

  // Working value and running results
  logic [NUM_W-1:0]   n;
  logic [COUNT_W-1:0] c;
  logic [SUM_W-1:0]   s;
  logic               arith;
  logic               comp;

  // Current trial divisor, its square and its factor totals
  logic [TRIAL_W-1:0] p;
  logic [PSQ_W-1:0]   psq;
  logic [FACT_W-1:0]  lc;
  logic [SUM_W-1:0]   ls;

  // Shared divider
  logic [SUM_W-1:0]   div_q;
  logic [TRIAL_W-1:0] div_r;
  logic [TRIAL_W-1:0] div_d;
  logic [STEP_W-1:0]  div_cnt;
  logic               div_final;

  // Shared shift-add multiplier
  logic [SUM_W-1:0]   mul_acc;
  logic [SUM_W-1:0]   mul_a;
  logic [SUM_W-1:0]   mul_b;
  logic               mul_to_ls;
  logic               mul_tail;

  // One restoring division step
  logic [TRIAL_W:0]   div_trial;
  logic               div_fits;
  logic [TRIAL_W-1:0] step_r;
  logic [SUM_W-1:0]   step_q;
  logic               div_last;

  always_comb begin
    div_trial = {div_r, div_q[SUM_W-1]};
    div_fits  = div_trial >= {1'b0, div_d};
    step_r    = div_fits ? TRIAL_W'(div_trial - {1'b0, div_d}) : div_trial[TRIAL_W-1:0];
    step_q    = {div_q[SUM_W-2:0], div_fits};
    div_last  = div_cnt == STEP_W'(DIV_STEPS - 1);
  end

  // Trial divisor advance
  logic [TRIAL_W-1:0] p_next;
  logic [PSQ_W-1:0]   psq_next;

  assign p_next   = p + TRIAL_STEP;
  assign psq_next = psq + PSQ_W'({p, 2'b00}) + PSQ_W'(4);

  assign in_ready = state == S_IDLE;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drain the output register unless a new result is loaded this cycle
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= number & NUMBER_MASK;
            arith <= 1'b0;
            comp  <= 1'b0;
            if ((number & NUMBER_MASK) == '0) begin
              c     <= '0;
              s     <= '0;
              state <= S_FINISH;
            end else begin
              c     <= COUNT_W'(1);
              s     <= SUM_W'(1);
              state <= S_STRIP;
            end
          end
        end

        // Strip factors of two: sum becomes 2^(k+1) - 1
        S_STRIP: begin
          if (!n[0]) begin
            n <= n >> 1;
            c <= c + COUNT_W'(1);
            s <= {s[SUM_W-2:0], 1'b1};
          end else begin
            p     <= TRIAL_FIRST;
            psq   <= TRIAL_SQ_FIRST;
            state <= S_TEST;
          end
        end

        // Next trial divisor, the leftover prime, or the final division of the sum by the count
        S_TEST: begin
          if (psq <= PSQ_W'(n)) begin
            lc        <= FACT_W'(1);
            ls        <= SUM_W'(1);
            div_q     <= SUM_W'(n);
            div_r     <= '0;
            div_d     <= p;
            div_cnt   <= '0;
            div_final <= 1'b0;
            state     <= S_DIV;
          end else if (n > NUM_W'(1)) begin
            c         <= {c[COUNT_W-2:0], 1'b0};
            mul_acc   <= '0;
            mul_a     <= s;
            mul_b     <= SUM_W'(n) + SUM_W'(1);
            mul_to_ls <= 1'b0;
            mul_tail  <= 1'b1;
            state     <= S_MUL;
          end else begin
            div_q     <= s;
            div_r     <= '0;
            div_d     <= TRIAL_W'(c);
            div_cnt   <= '0;
            div_final <= 1'b1;
            state     <= S_DIV;
          end
        end

        S_DIV: begin
          div_q   <= step_q;
          div_r   <= step_r;
          div_cnt <= div_cnt + STEP_W'(1);
          if (div_last) begin
            if (div_final) begin
              arith <= step_r == '0;
              comp  <= (step_r == '0) && (c > COUNT_W'(2));
              state <= S_FINISH;
            end else if (step_r == '0) begin
              // Factor found: divide it out, ls = ls * p + 1
              n         <= step_q[NUM_W-1:0];
              lc        <= lc + FACT_W'(1);
              mul_acc   <= SUM_W'(1);
              mul_a     <= ls;
              mul_b     <= SUM_W'(p);
              mul_to_ls <= 1'b1;
              mul_tail  <= 1'b0;
              state     <= S_MUL;
            end else if (lc != FACT_W'(1)) begin
              // Fold this prime's totals into the running results
              c         <= COUNT_W'(c * COUNT_W'(lc));
              mul_acc   <= '0;
              mul_a     <= s;
              mul_b     <= ls;
              mul_to_ls <= 1'b0;
              mul_tail  <= 1'b0;
              state     <= S_MUL;
            end else begin
              p     <= p_next;
              psq   <= psq_next;
              state <= S_TEST;
            end
          end
        end

        // Shift-add multiply, ends when the multiplier runs out of ones
        S_MUL: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              mul_acc <= mul_acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (mul_to_ls) begin
            ls        <= mul_acc;
            div_q     <= SUM_W'(n);
            div_r     <= '0;
            div_d     <= p;
            div_cnt   <= '0;
            div_final <= 1'b0;
            state     <= S_DIV;
          end else if (mul_tail) begin
            s         <= mul_acc;
            div_q     <= mul_acc;
            div_r     <= '0;
            div_d     <= TRIAL_W'(c);
            div_cnt   <= '0;
            div_final <= 1'b1;
            state     <= S_DIV;
          end else begin
            s     <= mul_acc;
            p     <= p_next;
            psq   <= psq_next;
            state <= S_TEST;
          end
        end

        // Hand the item to the output register once it is free
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            num_divisors            <= c;
            sigma                   <= s;
            is_arith                <= arith;
            is_composite_arithmetic <= comp;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
